// ----- rtl/cedv_pkg.sv -----
// Package for the complex element-wise divider: widths, payload structs and
// the output clamp function. No dependencies.
`default_nettype none
package cedv_pkg;

    localparam int FIELD_W       = 32;
    localparam int SAMPLE_WIDTH  = 32;
    localparam int FRACTION_BITS = 16;
    localparam int PROD_W        = 2 * SAMPLE_WIDTH;
    localparam int SUM_W         = PROD_W + 1;
    localparam int MAG_W         = PROD_W;
    // input reg, multiply, add, magnitude, divider entry, quotient bits, output reg
    localparam int LATENCY       = 6 + SAMPLE_WIDTH;

    typedef struct packed {
        logic signed [FIELD_W-1:0] numerator_real;
        logic signed [FIELD_W-1:0] numerator_imag;
        logic signed [FIELD_W-1:0] denominator_real;
        logic signed [FIELD_W-1:0] denominator_imag;
    } t_div_in;

    typedef struct packed {
        logic signed [FIELD_W-1:0] quotient_real;
        logic signed [FIELD_W-1:0] quotient_imag;
        logic                      divide_by_zero;
        logic                      saturated;
    } t_div_out;

    typedef struct packed {
        logic neg_r;
        logic neg_i;
        logic dz;
    } t_side;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    sat;
    } t_part;

    // Clamp a quotient magnitude to the signed range and apply the sign.
    function automatic t_part clamp_part(input logic [SAMPLE_WIDTH-1:0] q,
                                         input logic ovf, input logic neg);
        logic [SAMPLE_WIDTH-1:0] lim;
        logic [SAMPLE_WIDTH-1:0] m;
        logic                    over;
        t_part                   p;
        lim = neg ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}} : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        over = ovf || (q > lim);
        m = over ? lim : q;
        p.value = neg ? (~m + 1'b1) : m;
        p.sat = over;
        return p;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/cedv_qdiv.sv -----
// Pipelined restoring divider: floor(num * 2^FRACTION_BITS / den), one
// quotient bit per stage, with an overflow flag. Depends on cedv_pkg.
`default_nettype none
module cedv_qdiv (
    input  wire logic                             i_clk,
    input  wire logic [cedv_pkg::MAG_W-1:0]       i_num,
    input  wire logic [cedv_pkg::MAG_W-1:0]       i_den,
    output logic      [cedv_pkg::SAMPLE_WIDTH-1:0] o_quot,
    output logic                                  o_ovf
);
    import cedv_pkg::*;

    localparam int QW = SAMPLE_WIDTH;
    localparam int XW = MAG_W + FRACTION_BITS;
    localparam int TW = XW - QW;

    logic [XW-1:0] x_ext;
    logic [TW-1:0] x_top;
    logic          top_ge;

    logic [MAG_W-1:0] r_rem [0:QW];
    logic [MAG_W-1:0] r_den [0:QW];
    logic [QW-1:0]    r_low [0:QW];
    logic [QW-1:0]    r_q   [0:QW];
    logic             r_ovf [0:QW];

    assign x_ext  = {i_num, {FRACTION_BITS{1'b0}}};
    assign x_top  = x_ext[XW-1:QW];
    // quotient needs more than QW bits when the top part reaches the divisor
    assign top_ge = {{(MAG_W-TW){1'b0}}, x_top} >= i_den;

    always_ff @(posedge i_clk) begin
        r_ovf[0] <= top_ge;
        r_rem[0] <= top_ge ? '0 : {{(MAG_W-TW){1'b0}}, x_top};
        r_den[0] <= i_den;
        r_low[0] <= x_ext[QW-1:0];
        r_q[0]   <= '0;
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [MAG_W:0]   n_shift;
        logic [MAG_W+1:0] n_diff;
        logic             n_ge;

        assign n_shift = {r_rem[k], r_low[k][QW-1]};
        assign n_diff  = {1'b0, n_shift} - {2'b00, r_den[k]};
        assign n_ge    = !n_diff[MAG_W+1];

        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= n_ge ? n_diff[MAG_W-1:0] : n_shift[MAG_W-1:0];
            r_den[k+1] <= r_den[k];
            r_low[k+1] <= {r_low[k][QW-2:0], 1'b0};
            r_q[k+1]   <= {r_q[k][QW-2:0], n_ge};
            r_ovf[k+1] <= r_ovf[k];
        end
    end

    assign o_quot = r_q[QW];
    assign o_ovf  = r_ovf[QW];

endmodule
`default_nettype wire

// ----- rtl/complex_elementwise_divider.sv -----
// Top level of the complex element-wise divider (signed fixed point).
// Depends on cedv_pkg and cedv_qdiv.
//
// Usage:
//   Request channel: drive i_req and pulse i_start; a request is taken at a
//   clock edge where i_start is high and o_busy is low. o_busy is low
//   whenever reset is released, so a request can be issued every cycle.
//   Result channel: o_result is shown for one cycle with o_strobe high,
//   after its request has passed the input register, multipliers,
//   adders, magnitude stage, divider entry, 32 quotient-bit stages of the
//   divider and output register. Throughput is one request per cycle.
//   The receiver cannot stall: each result is gone after its strobe cycle.
//   Configuration: i_cfg_data[0] sets complex mode (1) or real mode (0);
//   written when i_cfg_valid and o_cfg_ready are high. Write only while no
//   request is in flight.
//   Reset (i_rst_n low, synchronous) sets complex mode and drops every
//   request in flight; no strobe follows for them.
`default_nettype none
module complex_elementwise_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire cedv_pkg::t_div_in  i_req,
    output logic                    o_strobe,
    output cedv_pkg::t_div_out      o_result,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic               i_cfg_data
);
    import cedv_pkg::*;

    localparam int SW = SAMPLE_WIDTH;

    logic r_mode;
    logic [LATENCY-1:0] r_vld;

    // stage 1
    logic signed [SW-1:0] r_a1, r_b1, r_c1, r_d1;
    logic                 r_mode1;
    // stage 2
    logic signed [PROD_W-1:0] r_ac, r_bd, r_bc, r_ad, r_cc, r_dd;
    logic signed [SW-1:0]     r_a2, r_c2;
    logic                     r_mode2;
    // stage 3
    logic signed [SUM_W-1:0] r_sn_r, r_sn_i, r_sd;
    // stage 4
    logic [MAG_W-1:0] r_num_r, r_num_i, r_den;
    t_side            r_side4;
    t_side            r_side [0:SW];

    logic [SW-1:0] quot_r, quot_i;
    logic          ovf_r, ovf_i;
    t_part         part_r, part_i;
    t_div_out      r_out;

    assign o_busy      = !i_rst_n;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
            r_vld  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_mode <= i_cfg_data;
            end
            r_vld <= {r_vld[LATENCY-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1    <= i_req.numerator_real[SW-1:0];
        r_b1    <= i_req.numerator_imag[SW-1:0];
        r_c1    <= i_req.denominator_real[SW-1:0];
        r_d1    <= i_req.denominator_imag[SW-1:0];
        r_mode1 <= r_mode;

        r_ac    <= r_a1 * r_c1;
        r_bd    <= r_b1 * r_d1;
        r_bc    <= r_b1 * r_c1;
        r_ad    <= r_a1 * r_d1;
        r_cc    <= r_c1 * r_c1;
        r_dd    <= r_d1 * r_d1;
        r_a2    <= r_a1;
        r_c2    <= r_c1;
        r_mode2 <= r_mode1;

        // real mode divides a by c directly
        if (r_mode2) begin
            r_sn_r <= SUM_W'(r_ac) + SUM_W'(r_bd);
            r_sn_i <= SUM_W'(r_bc) - SUM_W'(r_ad);
            r_sd   <= SUM_W'(r_cc) + SUM_W'(r_dd);
        end else begin
            r_sn_r <= SUM_W'(r_a2);
            r_sn_i <= '0;
            r_sd   <= SUM_W'(r_c2);
        end

        r_num_r <= r_sn_r[SUM_W-1] ? MAG_W'(-r_sn_r) : MAG_W'(r_sn_r);
        r_num_i <= r_sn_i[SUM_W-1] ? MAG_W'(-r_sn_i) : MAG_W'(r_sn_i);
        r_den   <= r_sd[SUM_W-1] ? MAG_W'(-r_sd) : MAG_W'(r_sd);
        r_side4.neg_r <= (r_sn_r[SUM_W-1] ^ r_sd[SUM_W-1]) && (r_sn_r != '0);
        r_side4.neg_i <= (r_sn_i[SUM_W-1] ^ r_sd[SUM_W-1]) && (r_sn_i != '0);
        r_side4.dz    <= (r_sd == '0);
    end

    cedv_qdiv u_div_r (
        .i_clk  (i_clk),
        .i_num  (r_num_r),
        .i_den  (r_den),
        .o_quot (quot_r),
        .o_ovf  (ovf_r)
    );

    cedv_qdiv u_div_i (
        .i_clk  (i_clk),
        .i_num  (r_num_i),
        .i_den  (r_den),
        .o_quot (quot_i),
        .o_ovf  (ovf_i)
    );

    // carry sign and zero-divisor flags alongside the divider
    always_ff @(posedge i_clk) begin
        r_side[0] <= r_side4;
        for (int k = 0; k < SW; k++) begin
            r_side[k+1] <= r_side[k];
        end
    end

    always_comb begin
        part_r = clamp_part(quot_r, ovf_r, r_side[SW].neg_r);
        part_i = clamp_part(quot_i, ovf_i, r_side[SW].neg_i);
    end

    always_ff @(posedge i_clk) begin
        if (r_side[SW].dz) begin
            r_out.quotient_real <= '0;
            r_out.quotient_imag <= '0;
            r_out.saturated     <= 1'b0;
        end else begin
            r_out.quotient_real <= FIELD_W'(signed'(part_r.value));
            r_out.quotient_imag <= FIELD_W'(signed'(part_i.value));
            r_out.saturated     <= part_r.sat || part_i.sat;
        end
        r_out.divide_by_zero <= r_side[SW].dz;
    end

    assign o_strobe = r_vld[LATENCY-1];
    assign o_result = r_out;

endmodule
`default_nettype wire

// ----- rtl/cedv_chk.sv -----
// Port-level checker for the complex element-wise divider, bound to the top.
// Depends on cedv_pkg.
`default_nettype none
module cedv_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_start,
    input wire logic               o_busy,
    input wire logic               o_strobe,
    input wire cedv_pkg::t_div_out o_result
);
    import cedv_pkg::*;

    localparam logic signed [FIELD_W-1:0] QMAX = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] QMIN = {1'b1, {(FIELD_W-1){1'b0}}};

    a_req_gets_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_strobe)
        else $error("request produced no result");

    a_result_has_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without request");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.divide_by_zero) |->
        (o_result.quotient_real == '0 && o_result.quotient_imag == '0
         && !o_result.saturated))
        else $error("zero divisor gave nonzero result");

    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.saturated) |->
        (o_result.quotient_real == QMAX || o_result.quotient_real == QMIN
         || o_result.quotient_imag == QMAX || o_result.quotient_imag == QMIN))
        else $error("saturated result not at a bound");

endmodule

bind complex_elementwise_divider cedv_chk u_cedv_chk (.*);
`default_nettype wire
